@@ sv/sha256_pkg.sv @@
// sha256 constants, round table, state type and rotate helper function
`default_nettype none
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

@@ sv/sha256_message_hasher_top.sv @@
// sha-256 message hasher: byte stream in, eight digest words out
//
// s_ channel: one message byte per transaction; tuser[0] marks whether tdata
// carries a byte, tlast closes the message after that byte.
// m_ channel: eight transactions per message, digest word 0 (most
// significant) first; tuser holds the word index, tlast marks word 7.
// A byte that does not complete a block is taken while the hasher stays idle,
// so the next byte can follow. A byte that fills a block runs the load, the
// rounds on the single round unit and the chaining add. A closing
// transaction runs one or two padding blocks, after the block it completes
// if any, then emits the digest words one per cycle the receiver accepts.
// s_axis_tready is low during all of this, and a stalled receiver holds the
// block in the emit phase.
// Message bytes collect in the 16-word schedule ring, and schedule words
// are computed in place in that ring as rounds run. After reset the
// chaining words hold the standard initial values and the block is ready
// at once.
`default_nettype none
module sha256_message_hasher_top
    import sha256_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tuser,   // has_byte
    input  wire logic        s_axis_tlast,   // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // digest_word
    output logic [2:0]       m_axis_tuser,   // word_index
    output logic             m_axis_tlast    // last_word
);

    state_t state_reg, state_next;
    logic [5:0]  fill_reg;
    logic [60:0] count_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  round_reg;
    logic [1:0]  pad_reg;     // 0 message block, 1 last padding block, 2 first of two
    logic [2:0]  idx_reg;
    logic        end_reg;     // message closed by the byte that filled the block

    logic        acc;
    logic [5:0]  fill_inc;
    logic [63:0] bits;
    logic [31:0] wt, s0, s1, wnew, t1, t2;
    logic [31:0] w16 [16];

    assign acc      = s_axis_tvalid && s_axis_tready;
    assign fill_inc = fill_reg + 6'd1;
    assign bits     = {count_reg, 3'b000};

    // padded block contents, word by word
    always_comb begin
        logic [7:0] b;
        logic [5:0] p;
        for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 4; j++) begin
                p = 6'(4 * i + j);
                if (pad_reg == 2'd0) begin
                    b = w_reg[i][31 - 8 * j -: 8];
                end else begin
                    if (p < fill_reg && pad_reg != 2'd3) b = w_reg[i][31 - 8 * j -: 8];
                    else if (p == fill_reg && pad_reg != 2'd3) b = PAD_BYTE;
                    else b = 8'h00;
                    if (pad_reg != 2'd2 && p >= LEN_POS) b = bits[8 * (63 - p) +: 8];
                end
                w16[i][31 - 8 * j -: 8] = b;
            end
        end
    end

    always_comb begin
        wt   = w_reg[0];
        s0   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        t1   = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[round_reg] + wt;
        t2   = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (acc && ((s_axis_tuser && fill_inc == 6'd0) || s_axis_tlast))
                    state_next = ST_LOAD;
            end
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: if (round_reg == 6'd63) state_next = ST_ADD;
            ST_ADD: begin
                if (pad_reg == 2'd2 || (pad_reg == 2'd0 && end_reg)) state_next = ST_LOAD;
                else if (pad_reg == 2'd0) state_next = ST_IDLE;
                else state_next = ST_EMIT;
            end
            ST_EMIT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready && idx_reg == 3'd7) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // pad_reg: 0 plain block, 1 final block with length, 2 first of two
    // (message end + 0x80, no length), 3 second of two (zeros + length)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            count_reg <= '0;
            pad_reg   <= 2'd0;
            idx_reg   <= '0;
            round_reg <= '0;
            end_reg   <= 1'b0;
            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_HASH[i];
        end else begin
            case (state_reg)
                ST_IDLE: if (acc) begin
                    if (s_axis_tuser) begin
                        for (int j = 0; j < 4; j++)
                            if (fill_reg[1:0] == 2'(j))
                                w_reg[fill_reg[5:2]][31 - 8 * j -: 8] <= s_axis_tdata;
                        fill_reg  <= fill_inc;
                        count_reg <= count_reg + 61'd1;
                    end
                    if (s_axis_tuser && fill_inc == 6'd0) begin
                        pad_reg <= 2'd0;
                        end_reg <= s_axis_tlast;
                    end else if (s_axis_tlast)
                        pad_reg <= ((s_axis_tuser ? fill_inc : fill_reg) >= LEN_POS) ?
                            2'd2 : 2'd1;
                end
                ST_LOAD: begin
                    for (int i = 0; i < 16; i++) w_reg[i] <= w16[i];
                    for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                    round_reg <= '0;
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i + 1];
                    w_reg[15] <= wnew;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    round_reg <= round_reg + 6'd1;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    if (pad_reg == 2'd2) pad_reg <= 2'd3;
                    else if (pad_reg == 2'd0 && end_reg) begin
                        pad_reg <= 2'd1;
                        end_reg <= 1'b0;
                    end
                    idx_reg <= '0;
                end
                ST_EMIT: if (m_axis_tready) begin
                    idx_reg <= idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        for (int i = 0; i < 8; i++) h_reg[i] <= INIT_HASH[i];
                        fill_reg  <= '0;
                        count_reg <= '0;
                        pad_reg   <= 2'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tdata = h_reg[idx_reg];
    assign m_axis_tuser = idx_reg;
    assign m_axis_tlast = idx_reg == 3'd7;

endmodule
`default_nettype wire
